/* hdl/vyp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vyp_pkg
// shared constants and types for the vertex yaw perspective projector
// ----------------------------------------------------------------------------
package vyp_pkg;

    localparam int SCREEN_WIDTH  = 512;
    localparam int SCREEN_HEIGHT = 320;

    // widths of the screen offset division
    localparam int W_BITS = $clog2(SCREEN_WIDTH + 1);
    localparam int NUM_W  = 25 + W_BITS + 12;
    localparam int DEN_W  = 41;
    localparam int QB     = 17;
    localparam int CMP_W  = DEN_W + QB;

    // register indexes of the config port
    localparam logic [2:0] REG_CAM_X   = 3'd0;
    localparam logic [2:0] REG_CAM_Y   = 3'd1;
    localparam logic [2:0] REG_CAM_Z   = 3'd2;
    localparam logic [2:0] REG_YAW_COS = 3'd3;
    localparam logic [2:0] REG_YAW_SIN = 3'd4;
    localparam logic [2:0] REG_TAN     = 3'd5;
    localparam logic [2:0] REG_FAR     = 3'd6;

    typedef struct packed {
        logic signed [23:0] cam_x;
        logic signed [23:0] cam_y;
        logic signed [23:0] cam_z;
        logic signed [15:0] yaw_cos;
        logic signed [15:0] yaw_sin;
        logic        [15:0] tan_half_fov;
        logic        [22:0] far_plane;
    } cfg_t;

    // flags that travel alongside the division
    typedef struct packed {
        logic               proj;
        logic               ind;
        logic               inx;
        logic               iny;
        logic               neg_x;
        logic               neg_y;
        logic signed [23:0] depth;
    } side_t;

endpackage

/* hdl/vertex_yaw_perspective_project.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_yaw_perspective_project
// projects world vertices onto the screen of a yawed camera
// ----------------------------------------------------------------------------
// a vertex word is taken on every clock edge where start is high; busy is
// always low, so one vertex may enter every cycle with no gaps. each vertex
// gives exactly one result word, shown for a single cycle with done high,
// after passing 5 front end stages, 18 divider stages and the output
// register. the divider resolves one quotient bit per stage. the receiver
// cannot stall the block, so the result must be captured in the cycle done
// is high. configuration must only be written while no vertex is in flight.
// ----------------------------------------------------------------------------
module vertex_yaw_perspective_project
(
    input  logic               clk,
    input  logic               rst_n,
    // config write port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    // vertex word in
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] vert_x,
    input  logic signed [23:0] vert_y,
    input  logic signed [23:0] vert_z,
    // result word out
    output logic               done,
    output logic signed [10:0] screen_x,
    output logic signed [15:0] screen_y,
    output logic signed [23:0] depth,
    output logic               in_distance,
    output logic               in_bounds_x,
    output logic               in_bounds_y,
    output logic               projected
);
    import vyp_pkg::*;

    // config registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cam_x        <= '0;
            cfg_reg.cam_y        <= '0;
            cfg_reg.cam_z        <= '0;
            cfg_reg.yaw_cos      <= 16'sd16384;
            cfg_reg.yaw_sin      <= '0;
            cfg_reg.tan_half_fov <= 16'd2868;
            cfg_reg.far_plane    <= 23'd25600;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CAM_X:   cfg_reg.cam_x        <= cfg_data;
                REG_CAM_Y:   cfg_reg.cam_y        <= cfg_data;
                REG_CAM_Z:   cfg_reg.cam_z        <= cfg_data;
                REG_YAW_COS: cfg_reg.yaw_cos      <= cfg_data[15:0];
                REG_YAW_SIN: cfg_reg.yaw_sin      <= cfg_data[15:0];
                REG_TAN:     cfg_reg.tan_half_fov <= cfg_data[15:0];
                REG_FAR:     cfg_reg.far_plane    <= cfg_data[22:0];
                default:     ;
            endcase
        end
    end

    // fully pipelined, never holds off a vertex
    assign busy = 1'b0;

    // front end: translate, rotate, clip, division setup
    logic             f_valid;
    logic [NUM_W-1:0] f_num_x, f_num_y;
    logic [DEN_W-1:0] f_den;
    side_t            f_side;

    vyp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (start & ~busy),
        .vert_x    (vert_x),
        .vert_y    (vert_y),
        .vert_z    (vert_z),
        .out_valid (f_valid),
        .num_x     (f_num_x),
        .num_y     (f_num_y),
        .den       (f_den),
        .side      (f_side)
    );

    // screen offset magnitudes |coord|*4096*width / (2*t*z)
    logic          d_valid;
    logic [QB-1:0] d_qx, d_qy;
    side_t         d_side;

    vyp_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .num_x     (f_num_x),
        .num_y     (f_num_y),
        .den       (f_den),
        .side_in   (f_side),
        .out_valid (d_valid),
        .quo_x     (d_qx),
        .quo_y     (d_qy),
        .side_out  (d_side)
    );

    // apply sign (truncation toward zero), add the screen center
    logic signed [18:0] off_x, off_y, sx_full, sy_full;
    logic signed [10:0] sx_next;
    logic signed [15:0] sy_next;
    logic signed [23:0] dep_next;

    assign off_x   = d_side.neg_x ? -$signed({2'b0, d_qx}) : $signed({2'b0, d_qx});
    assign off_y   = d_side.neg_y ? -$signed({2'b0, d_qy}) : $signed({2'b0, d_qy});
    assign sx_full = 19'(SCREEN_WIDTH / 2) + off_x;
    assign sy_full = 19'(SCREEN_HEIGHT / 2) + off_y;

    always_comb
    begin
        if (d_side.proj)
        begin
            sx_next  = sx_full[10:0];
            // row saturates to 16 bits
            if (sy_full > 19'sd32767)
            begin
                sy_next = 16'sh7FFF;
            end
            else if (sy_full < -19'sd32768)
            begin
                sy_next = 16'sh8000;
            end
            else
            begin
                sy_next = sy_full[15:0];
            end
            dep_next = d_side.depth;
        end
        else
        begin
            // not projected markers
            sx_next  = -11'sd1;
            sy_next  = -16'sd1;
            dep_next = -24'sd256;
        end
    end

    logic               done_reg;
    logic signed [10:0] screen_x_reg;
    logic signed [15:0] screen_y_reg;
    logic signed [23:0] depth_reg;
    logic               ind_reg, inx_reg, iny_reg, proj_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        screen_x_reg <= sx_next;
        screen_y_reg <= sy_next;
        depth_reg    <= dep_next;
        ind_reg      <= d_side.ind;
        inx_reg      <= d_side.inx;
        iny_reg      <= d_side.iny;
        proj_reg     <= d_side.proj;
    end

    assign done        = done_reg;
    assign screen_x    = screen_x_reg;
    assign screen_y    = screen_y_reg;
    assign depth       = depth_reg;
    assign in_distance = ind_reg;
    assign in_bounds_x = inx_reg;
    assign in_bounds_y = iny_reg;
    assign projected   = proj_reg;

endmodule

/* hdl/vyp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vyp_front
// five stage front end: translate, rotate, bound, clip, set up division
// ----------------------------------------------------------------------------
module vyp_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  vyp_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    input  logic signed [23:0]    vert_x,
    input  logic signed [23:0]    vert_y,
    input  logic signed [23:0]    vert_z,
    output logic                  out_valid,
    output logic [vyp_pkg::NUM_W-1:0] num_x,
    output logic [vyp_pkg::NUM_W-1:0] num_y,
    output logic [vyp_pkg::DEN_W-1:0] den,
    output vyp_pkg::side_t        side
);
    import vyp_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 1: translate
    logic signed [24:0] dx1_reg, dy1_reg, dz1_reg;
    logic signed [24:0] dx1_next, dy1_next, dz1_next;
    // stage 2: rotation products
    logic signed [40:0] pxc_reg, pzs_reg, pxs_reg, pzc_reg;
    logic signed [40:0] pxc_next, pzs_next, pxs_next, pzc_next;
    logic signed [24:0] dy2_reg;
    // stage 3: rotated, floored, saturated
    logic signed [41:0] xsum, zsum, xsh, zsh;
    logic signed [23:0] xr3_next, zr3_next, zsat;
    logic signed [23:0] xr3_reg, zr3_reg;
    logic signed [24:0] dy3_reg;
    // stage 4: bound
    logic signed [40:0] lim4_reg, lim4_next;
    logic signed [23:0] xr4_reg, zr4_reg;
    logic signed [24:0] dy4_reg;
    // stage 5: clip tests and division setup
    logic signed [40:0] xs, ys;
    logic               ind, inx, iny, proj;
    logic [24:0]        mag_x, mag_y;
    logic [25:0]        dy_neg;
    logic [NUM_W-1:0]   num_x_next, num_y_next, num_x_reg, num_y_reg;
    logic [DEN_W-1:0]   den_next, den_reg;
    side_t              side_next, side_reg;

    assign dx1_next = {vert_x[23], vert_x} - {cfg.cam_x[23], cfg.cam_x};
    assign dy1_next = {vert_y[23], vert_y} - {cfg.cam_y[23], cfg.cam_y};
    assign dz1_next = {vert_z[23], vert_z} - {cfg.cam_z[23], cfg.cam_z};

    assign pxc_next = dx1_reg * cfg.yaw_cos;
    assign pzs_next = dz1_reg * cfg.yaw_sin;
    assign pxs_next = dx1_reg * cfg.yaw_sin;
    assign pzc_next = dz1_reg * cfg.yaw_cos;

    assign xsum = pxc_reg - pzs_reg;
    assign zsum = pxs_reg + pzc_reg;
    assign xsh  = xsum >>> 14;
    assign zsh  = zsum >>> 14;

    always_comb
    begin
        if (xsh > 42'sd8388607)
        begin
            xr3_next = 24'sh7FFFFF;
        end
        else if (xsh < -42'sd8388608)
        begin
            xr3_next = 24'sh800000;
        end
        else
        begin
            xr3_next = xsh[23:0];
        end
        if (zsh > 42'sd8388607)
        begin
            zsat = 24'sh7FFFFF;
        end
        else if (zsh < -42'sd8388608)
        begin
            zsat = 24'sh800000;
        end
        else
        begin
            zsat = zsh[23:0];
        end
        // zero depth becomes about 0.01
        zr3_next = (zsat == 24'sd0) ? 24'sd3 : zsat;
    end

    assign lim4_next = zr3_reg * $signed({1'b0, cfg.tan_half_fov});

    assign xs   = $signed({{5{xr4_reg[23]}}, xr4_reg, 12'b0});
    assign ys   = $signed({{4{dy4_reg[24]}}, dy4_reg, 12'b0});
    assign ind  = zr4_reg < $signed({1'b0, cfg.far_plane});
    assign inx  = (xs < lim4_reg) && (xs > -lim4_reg);
    assign iny  = (ys < lim4_reg) && (ys > -lim4_reg);
    assign proj = ind && inx;

    assign mag_x  = xr4_reg[23] ? 25'(-$signed({xr4_reg[23], xr4_reg}))
                                : {1'b0, xr4_reg};
    assign dy_neg = 26'(-$signed({dy4_reg[24], dy4_reg}));
    assign mag_y  = dy4_reg[24] ? dy_neg[24:0] : dy4_reg[24:0];

    always_comb
    begin
        if (proj)
        begin
            num_x_next = NUM_W'({mag_x, 12'b0}) * NUM_W'(SCREEN_WIDTH);
            num_y_next = NUM_W'({mag_y, 12'b0}) * NUM_W'(SCREEN_WIDTH);
            den_next   = {lim4_reg[39:0], 1'b0};
        end
        else
        begin
            num_x_next = '0;
            num_y_next = '0;
            den_next   = DEN_W'(1);
        end
        side_next.proj  = proj;
        side_next.ind   = ind;
        side_next.inx   = inx;
        side_next.iny   = iny;
        side_next.neg_x = xr4_reg[23];
        side_next.neg_y = dy4_reg[24];
        side_next.depth = zr4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx1_reg   <= dx1_next;
        dy1_reg   <= dy1_next;
        dz1_reg   <= dz1_next;
        pxc_reg   <= pxc_next;
        pzs_reg   <= pzs_next;
        pxs_reg   <= pxs_next;
        pzc_reg   <= pzc_next;
        dy2_reg   <= dy1_reg;
        xr3_reg   <= xr3_next;
        zr3_reg   <= zr3_next;
        dy3_reg   <= dy2_reg;
        lim4_reg  <= lim4_next;
        xr4_reg   <= xr3_reg;
        zr4_reg   <= zr3_reg;
        dy4_reg   <= dy3_reg;
        num_x_reg <= num_x_next;
        num_y_reg <= num_y_next;
        den_reg   <= den_next;
        side_reg  <= side_next;
    end

    assign out_valid = v5_reg;
    assign num_x     = num_x_reg;
    assign num_y     = num_y_reg;
    assign den       = den_reg;
    assign side      = side_reg;

endmodule

/* hdl/vyp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vyp_div
// two lane pipelined restoring divider, one quotient bit per stage,
// quotient saturates at all ones
// ----------------------------------------------------------------------------
module vyp_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [vyp_pkg::NUM_W-1:0] num_x,
    input  logic [vyp_pkg::NUM_W-1:0] num_y,
    input  logic [vyp_pkg::DEN_W-1:0] den,
    input  vyp_pkg::side_t            side_in,
    output logic                      out_valid,
    output logic [vyp_pkg::QB-1:0]    quo_x,
    output logic [vyp_pkg::QB-1:0]    quo_y,
    output vyp_pkg::side_t            side_out
);
    import vyp_pkg::*;

    logic             v_reg    [QB+1];
    logic [NUM_W-1:0] rx_reg   [QB+1];
    logic [NUM_W-1:0] ry_reg   [QB+1];
    logic [QB-1:0]    qx_reg   [QB+1];
    logic [QB-1:0]    qy_reg   [QB+1];
    logic [DEN_W-1:0] d_reg    [QB+1];
    side_t            s_reg    [QB+1];

    // stage 0: overflow test against den shifted by the quotient width
    logic [CMP_W-1:0] d_top;
    logic             ovf_x, ovf_y;

    assign d_top = {den, {QB{1'b0}}};
    assign ovf_x = CMP_W'(num_x) >= d_top;
    assign ovf_y = CMP_W'(num_y) >= d_top;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg[0] <= ovf_x ? '0 : num_x;
        ry_reg[0] <= ovf_y ? '0 : num_y;
        qx_reg[0] <= ovf_x ? '1 : '0;
        qy_reg[0] <= ovf_y ? '1 : '0;
        d_reg[0]  <= den;
        s_reg[0]  <= side_in;
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        localparam int BIT = QB - k;
        logic [CMP_W-1:0] dsh;
        logic             gx, gy;
        logic [CMP_W-1:0] rx_ext, ry_ext;
        logic [CMP_W-1:0] rx_sub, ry_sub;
        logic [QB-1:0]    bitmask;

        assign dsh     = CMP_W'(d_reg[k-1]) << BIT;
        assign rx_ext  = CMP_W'(rx_reg[k-1]);
        assign ry_ext  = CMP_W'(ry_reg[k-1]);
        assign gx      = rx_ext >= dsh;
        assign gy      = ry_ext >= dsh;
        assign rx_sub  = rx_ext - dsh;
        assign ry_sub  = ry_ext - dsh;
        assign bitmask = QB'(1) << BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rx_reg[k] <= gx ? rx_sub[NUM_W-1:0] : rx_reg[k-1];
            ry_reg[k] <= gy ? ry_sub[NUM_W-1:0] : ry_reg[k-1];
            qx_reg[k] <= gx ? (qx_reg[k-1] | bitmask) : qx_reg[k-1];
            qy_reg[k] <= gy ? (qy_reg[k-1] | bitmask) : qy_reg[k-1];
            d_reg[k]  <= d_reg[k-1];
            s_reg[k]  <= s_reg[k-1];
        end
    end

    assign out_valid = v_reg[QB];
    assign quo_x     = qx_reg[QB];
    assign quo_y     = qy_reg[QB];
    assign side_out  = s_reg[QB];

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the vertex yaw perspective projector against a cycle-free predictor:
// directed corner vertices, register sweeps and random vertex streams, with
// random sender gaps in all but one stream; every result word checked per field
// ----------------------------------------------------------------------------
module testbench;
    import vyp_pkg::*;

    localparam int LATENCY   = 24;
    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic signed [10:0] sx;
        logic signed [15:0] sy;
        logic signed [23:0] dep;
        logic               ind;
        logic               inx;
        logic               iny;
        logic               proj;
    } projection_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [23:0]        cfg_data;
    logic               start;
    logic               busy;
    logic signed [23:0] vert_x;
    logic signed [23:0] vert_y;
    logic signed [23:0] vert_z;
    logic               done;
    logic signed [10:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [23:0] depth;
    logic               in_distance;
    logic               in_bounds_x;
    logic               in_bounds_y;
    logic               projected;

    // local copy of the camera registers
    cfg_t camera;

    projection_t pending_q[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          no_gaps;

    vertex_yaw_perspective_project uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .vert_z      (vert_z),
        .done        (done),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .depth       (depth),
        .in_distance (in_distance),
        .in_bounds_x (in_bounds_x),
        .in_bounds_y (in_bounds_y),
        .projected   (projected)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // floor division by 2^14
    function automatic longint floor_q14(input longint s);
        if (s >= 0)
            return s / 16384;
        return -((-s + 16383) / 16384);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // project one vertex with the current camera
    function automatic projection_t project_vertex(input logic signed [23:0] wx,
                                                   input logic signed [23:0] wy,
                                                   input logic signed [23:0] wz);
        longint dx, dy, dz, c, s, t, xr, zr, lim, xs, ys, den, sx, sy, dep;
        bit ind, inx, iny, proj;
        projection_t r;
        dx = longint'(wx) - longint'(camera.cam_x);
        dy = longint'(wy) - longint'(camera.cam_y);
        dz = longint'(wz) - longint'(camera.cam_z);
        c = longint'(camera.yaw_cos);
        s = longint'(camera.yaw_sin);
        t = longint'({1'b0, camera.tan_half_fov});
        xr = clamp(floor_q14(dx * c - dz * s), -8388608, 8388607);
        zr = clamp(floor_q14(dx * s + dz * c), -8388608, 8388607);
        // zero depth is pushed just in front of the camera
        if (zr == 0)
            zr = 3;
        lim = t * zr;
        xs = xr * 4096;
        ys = dy * 4096;
        ind = zr < longint'({1'b0, camera.far_plane});
        inx = (xs < lim) && (xs > -lim);
        iny = (ys < lim) && (ys > -lim);
        proj = ind && inx;
        sx = -1;
        sy = -1;
        dep = -256;
        if (proj && lim > 0)
        begin
            den = 2 * lim;
            sx = SCREEN_WIDTH / 2 + (xs * SCREEN_WIDTH) / den;
            sy = clamp(SCREEN_HEIGHT / 2 + (ys * SCREEN_WIDTH) / den, -32768, 32767);
            dep = zr;
        end
        r.sx = sx[10:0];
        r.sy = sy[15:0];
        r.dep = dep[23:0];
        r.ind = ind;
        r.inx = inx;
        r.iny = iny;
        r.proj = proj;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // result word checker
    always @(posedge clk)
    begin
        projection_t want;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
                report_mismatch("unexpected word", 0, 0);
            else
            begin
                want = pending_q.pop_front();
                if (screen_x !== want.sx)
                    report_mismatch("screen_x", screen_x, want.sx);
                if (screen_y !== want.sy)
                    report_mismatch("screen_y", screen_y, want.sy);
                if (depth !== want.dep)
                    report_mismatch("depth", depth, want.dep);
                if (in_distance !== want.ind)
                    report_mismatch("in_distance", in_distance, want.ind);
                if (in_bounds_x !== want.inx)
                    report_mismatch("in_bounds_x", in_bounds_x, want.inx);
                if (in_bounds_y !== want.iny)
                    report_mismatch("in_bounds_y", in_bounds_y, want.iny);
                if (projected !== want.proj)
                    report_mismatch("projected", projected, want.proj);
            end
        end
    end

    // send one vertex word, with a random gap ahead of it unless no_gaps is set
    task automatic send_vertex(input logic signed [23:0] wx,
                               input logic signed [23:0] wy,
                               input logic signed [23:0] wz);
        while (!no_gaps && $urandom_range(99) < 34)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        vert_x <= wx;
        vert_y <= wy;
        vert_z <= wz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_q.push_back(project_vertex(wx, wy, wz));
    endtask

    // let the pipe empty out
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CAM_X:   camera.cam_x = value;
            REG_CAM_Y:   camera.cam_y = value;
            REG_CAM_Z:   camera.cam_z = value;
            REG_YAW_COS: camera.yaw_cos = value[15:0];
            REG_YAW_SIN: camera.yaw_sin = value[15:0];
            REG_TAN:     camera.tan_half_fov = value[15:0];
            REG_FAR:     camera.far_plane = value[22:0];
            default: ;
        endcase
    endtask

    task automatic set_camera(input int cx, input int cy, input int cz, input int c,
                              input int s, input int t, input int f);
        write_reg(REG_CAM_X, cx[23:0]);
        write_reg(REG_CAM_Y, cy[23:0]);
        write_reg(REG_CAM_Z, cz[23:0]);
        write_reg(REG_YAW_COS, c[23:0]);
        write_reg(REG_YAW_SIN, s[23:0]);
        write_reg(REG_TAN, t[23:0]);
        write_reg(REG_FAR, f[23:0]);
    endtask

    // a vertex somewhere near the view cone, mostly in front of the camera
    task automatic send_near_view();
        int zd, xd, yd;
        zd = $urandom_range(12000) - 500;
        xd = (int'($urandom_range(2 * zd + 600)) - zd - 300) / 2;
        yd = (int'($urandom_range(2 * zd + 600)) - zd - 300) / 2;
        send_vertex(24'(camera.cam_x + xd), 24'(camera.cam_y + yd),
                    24'(camera.cam_z + zd));
    endtask

    task automatic send_any();
        send_vertex(24'($urandom), 24'($urandom), 24'($urandom));
    endtask

    // corners of the fields and the special cases under the reset camera
    task automatic test_directed();
        send_vertex(0, 0, 0);                       // zero depth
        send_vertex(0, 0, 256);                     // dead center
        send_vertex(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_vertex(24'sh800000, 24'sh800000, 24'sh800000);
        send_vertex(0, 0, -256);                    // behind the camera
        send_vertex(60, 0, 256);                    // inside on x
        send_vertex(-60, 0, 256);
        send_vertex(0, 5000, 256);                  // off the top, outside on y
        send_vertex(0, -24'sd100000, 256);
        send_vertex(0, 0, 25599);                   // just before the far plane
        send_vertex(0, 0, 25600);                   // on the far plane
        send_vertex(-1, -1, -1);
        send_vertex(24'sh555555, 24'shAAAAAA, 24'sh555555);
        send_vertex(24'shAAAAAA, 24'sh555555, 24'shAAAAAA);
        drain();
    endtask

    // register extremes: zero tangent, extreme yaw values, far camera, zero far plane
    task automatic test_register_corners();
        set_camera(0, 0, 0, 16384, 0, 0, 25600);
        send_vertex(0, 0, 256);
        send_vertex(10, 10, 1000);
        drain();
        set_camera(-8388608, 8388607, -8388608, -16384, 16384, 65535, 8388607);
        repeat (12)
            send_any();
        send_vertex(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
        drain();
        set_camera(8388607, -8388608, 8388607, 0, -16384, 1, 0);
        repeat (8)
            send_any();
        drain();
    endtask

    // random cameras, mostly vertices near the view cone
    task automatic test_random_stream(input int count, input bit gapless);
        no_gaps = gapless;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
            begin
                drain();
                set_camera(int'($urandom_range(40000)) - 20000,
                           int'($urandom_range(40000)) - 20000,
                           int'($urandom_range(40000)) - 20000,
                           int'($urandom_range(32768)) - 16384,
                           int'($urandom_range(32768)) - 16384,
                           $urandom_range(1, 65535),
                           $urandom_range(8388607));
            end
            if ($urandom_range(99) < 80)
                send_near_view();
            else
                send_any();
        end
        no_gaps = 1'b0;
        drain();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_CAM_X;
        cfg_data    = '0;
        start       = 1'b0;
        vert_x      = '0;
        vert_y      = '0;
        vert_z      = '0;
        no_gaps     = 1'b0;
        camera.cam_x = 0;
        camera.cam_y = 0;
        camera.cam_z = 0;
        camera.yaw_cos = 16384;
        camera.yaw_sin = 0;
        camera.tan_half_fov = 2868;
        camera.far_plane = 25600;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_corners();
        test_random_stream(1100, 1'b0);
        test_random_stream(400, 1'b1);
        test_random_stream(400, 1'b0);

        repeat (LATENCY + 8)
            @(posedge clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("== PASS ==");
        else
        begin
            $display("%0d mismatches, %0d words missing", mismatches, pending_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
